// ===== hw/rtl/hpd_pkg.sv =====
// shared constants and types for the heater pid duty controller
package hpd_pkg;

  localparam int IntegralWidthDefault = 32;
  localparam int MeasWidth            = 13;
  localparam int ErrWidth             = 14;
  localparam int GainWidth            = 16;
  localparam int DutyWidth            = 8;
  localparam int OutShift             = 12;
  localparam int CfgIdxWidth          = 3;
  localparam int CfgDataWidth         = 16;
  localparam int ProdWidth            = MeasWidth + GainWidth;

  localparam logic [DutyWidth-1:0] DutyMax = 8'd255;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_ENABLE    = 3'd0,
    CFG_SETPOINT  = 3'd1,
    CFG_GAIN_P    = 3'd2,
    CFG_GAIN_I_DT = 3'd3,
    CFG_GAIN_D_DT = 3'd4
  } cfg_reg_e;

endpackage

// ===== hw/rtl/heater_pid_duty.sv =====
// heater pid duty controller: positional pid step from measured temperature to pwm duty
// an accepted input passes the input register, then the result register; the pid math runs
// in one pass between the two registers; one item per cycle while the result register is free
// unless disabled or off, the integral and last error update in that pass; the next item sees them
// reset: asynchronous, active low; clears config registers, pid state and both valid flags
// results stall in the result register; the input side stalls only when that register is blocked
module heater_pid_duty #(
  parameter int INTEGRAL_WIDTH = hpd_pkg::IntegralWidthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hpd_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [hpd_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [hpd_pkg::MeasWidth-1:0]   measured_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [hpd_pkg::DutyWidth-1:0]   duty_o,
  output logic                            updated_o
);

  localparam int IW = INTEGRAL_WIDTH;
  localparam int PW = hpd_pkg::ProdWidth;
  localparam int SW = ((IW > PW) ? IW : PW) + 1;
  localparam int TW = ((IW > 32) ? IW : 32) + 2;
  localparam int DW = hpd_pkg::DutyWidth;
  localparam int HiLsb = hpd_pkg::OutShift + DW;
  localparam logic [IW-1:0] IMax = {1'b0, {(IW-1){1'b1}}};

  // configuration registers
  logic                               enable_q;
  logic [hpd_pkg::MeasWidth-1:0]      setpoint_q;
  logic [hpd_pkg::GainWidth-1:0]      gain_p_q, gain_i_q, gain_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      setpoint_q <= '0;
      gain_p_q   <= '0;
      gain_i_q   <= '0;
      gain_d_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (hpd_pkg::cfg_reg_e'(cfg_idx_i))
        hpd_pkg::CFG_ENABLE:    enable_q   <= cfg_data_i[0];
        hpd_pkg::CFG_SETPOINT:  setpoint_q <= cfg_data_i[hpd_pkg::MeasWidth-1:0];
        hpd_pkg::CFG_GAIN_P:    gain_p_q   <= cfg_data_i;
        hpd_pkg::CFG_GAIN_I_DT: gain_i_q   <= cfg_data_i;
        hpd_pkg::CFG_GAIN_D_DT: gain_d_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register and result register handshake
  logic                          s1_valid_q;
  logic [hpd_pkg::MeasWidth-1:0] s1_meas_q;
  logic                          out_valid_q;
  logic [DW-1:0]                 out_duty_q;
  logic                          out_upd_q;
  logic                          s1_adv;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_meas_q <= measured_i;
    end
  end

  // pid state
  logic [hpd_pkg::ErrWidth-1:0] prior_q;
  logic [IW-1:0]                integral_q;
  logic [DW-1:0]                duty_held_q;

  // single pass pid math
  logic                          off;
  logic [hpd_pkg::MeasWidth-1:0] err;
  logic [PW-1:0]                 p_prod, i_add;
  logic [SW-1:0]                 i_sum;
  logic [IW-1:0]                 i_next;
  logic signed [hpd_pkg::ErrWidth:0] derr;
  logic signed [31:0]            d_prod;
  logic signed [TW-1:0]          total;
  logic [DW-1:0]                 pid_duty;
  logic [DW-1:0]                 duty_d;
  logic                          upd_d;

  always_comb begin
    off    = (setpoint_q == '0) || (s1_meas_q > setpoint_q);
    err    = setpoint_q - s1_meas_q;
    p_prod = PW'(err) * PW'(gain_p_q);
    i_add  = PW'(err) * PW'(gain_i_q);
    i_sum  = SW'(integral_q) + SW'(i_add);
    // saturate the integral at its largest positive value
    i_next = (i_sum > SW'(IMax)) ? IMax : i_sum[IW-1:0];
    derr   = $signed({2'b00, err}) - $signed({1'b0, prior_q});
    d_prod = 32'(derr) * $signed({16'b0, gain_d_q});
    total  = $signed(TW'(p_prod)) + $signed(TW'(i_next)) + TW'(d_prod);
    if (total <= 0) begin
      pid_duty = '0;
    end else if (total[TW-2:HiLsb] != '0) begin
      pid_duty = hpd_pkg::DutyMax;
    end else begin
      pid_duty = total[HiLsb-1:hpd_pkg::OutShift];
    end
    if (!enable_q) begin
      duty_d = duty_held_q;
      upd_d  = 1'b0;
    end else if (off) begin
      duty_d = '0;
      upd_d  = 1'b1;
    end else begin
      duty_d = pid_duty;
      upd_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q     <= '0;
      integral_q  <= '0;
      duty_held_q <= '0;
    end else if (s1_adv && enable_q) begin
      duty_held_q <= duty_d;
      if (!off) begin
        prior_q    <= {1'b0, err};
        integral_q <= i_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_duty_q <= duty_d;
      out_upd_q  <= upd_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign duty_o      = out_duty_q;
  assign updated_o   = out_upd_q;

  // integral is never negative
  a_integral_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !integral_q[IW-1])
    else $error("integral went negative");

  // a disabled item leaves the pid state alone
  a_disabled_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !enable_q) |=> ($stable(integral_q) && $stable(prior_q)
                               && $stable(duty_held_q)))
    else $error("pid state changed while disabled");

  // input side only stalls when the result register is occupied
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  // an off tick reports duty zero
  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && enable_q && off) |=> (out_valid_q && duty_o == '0 && updated_o))
    else $error("off tick gave nonzero duty");

endmodule

// ===== tb/heater_pid_duty_test.sv =====
// self-checking testbench for the heater pid duty controller
`timescale 1ns / 1ps

module heater_pid_duty_test;

  localparam int HalfPeriod   = 4;
  localparam int ResetCycles  = 8;
  localparam int IntegralBits = hpd_pkg::IntegralWidthDefault;
  localparam longint IntegralCap = (longint'(1) << (IntegralBits - 1)) - 1;
  localparam int NumCfgRegs   = int'(hpd_pkg::CFG_GAIN_D_DT) + 1;
  localparam int CfgIdxTop    = (1 << hpd_pkg::CfgIdxWidth) - 1;
  localparam int MeasTop      = (1 << hpd_pkg::MeasWidth) - 1;
  localparam int GainTop      = (1 << hpd_pkg::GainWidth) - 1;
  localparam int RandPhases   = 9;
  localparam int PhaseItems   = 53;
  localparam int DrainCycles  = 4;
  localparam int StallLimit   = 4000;
  localparam int NumDirRows   = 24;

  typedef logic [hpd_pkg::MeasWidth-1:0] meas_t;
  typedef logic [hpd_pkg::GainWidth-1:0] gain_t;
  typedef logic [hpd_pkg::DutyWidth-1:0] duty_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_PATTERN
  } stall_mode_e;

  typedef struct {
    duty_t duty;
    logic  updated;
  } duty_expect_t;

  typedef struct {
    bit    wr_cfg;
    logic  en;
    meas_t sp;
    gain_t kp;
    gain_t ki;
    gain_t kd;
    meas_t meas;
    bit    known;
    duty_t duty;
    logic  updated;
  } dir_row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [hpd_pkg::CfgIdxWidth-1:0]  cfg_idx_i = hpd_pkg::CFG_ENABLE;
  logic [hpd_pkg::CfgDataWidth-1:0] cfg_data_i = '0;
  logic                             in_valid_i = 1'b0;
  logic                             in_stall_o;
  meas_t                            measured_i = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  duty_t                            duty_o;
  logic                             updated_o;

  heater_pid_duty dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .measured_i,
    .out_valid_o,
    .out_stall_i,
    .duty_o,
    .updated_o
  );

  always #HalfPeriod clk_i = ~clk_i;

  // controller copy: configuration and pid state
  logic   ctl_enable = 1'b0;
  meas_t  ctl_setpoint = '0;
  gain_t  ctl_kp = '0;
  gain_t  ctl_ki = '0;
  gain_t  ctl_kd = '0;
  logic [hpd_pkg::ErrWidth-1:0] last_error = '0;
  longint integral_acc = 0;
  duty_t  duty_last = '0;

  duty_expect_t duty_expect_q[$];
  int           mismatches = 0;
  int           burst_left = 0;

  // after reset, disabled, zero setpoint, full-scale drive, negative error,
  // negative and clamped pid sums
  dir_row_t dir_rows [NumDirRows] = '{
    '{1'b0, 1'b0, 13'd0,    16'd0,     16'd0, 16'd0,     13'd0,    1'b1, 8'd0,   1'b0},
    '{1'b0, 1'b0, 13'd0,    16'd0,     16'd0, 16'd0,     13'd8191, 1'b1, 8'd0,   1'b0},
    '{1'b1, 1'b0, 13'd100,  16'd0,     16'd0, 16'd0,     13'd50,   1'b1, 8'd0,   1'b0},
    '{1'b1, 1'b1, 13'd0,    16'd65535, 16'd0, 16'd65535, 13'd0,    1'b1, 8'd0,   1'b1},
    '{1'b0, 1'b1, 13'd0,    16'd0,     16'd0, 16'd0,     13'd8191, 1'b1, 8'd0,   1'b1},
    '{1'b1, 1'b1, 13'd8191, 16'd65535, 16'd0, 16'd0,     13'd0,    1'b1, 8'd255, 1'b1},
    '{1'b0, 1'b1, 13'd0,    16'd0,     16'd0, 16'd0,     13'd8191, 1'b1, 8'd0,   1'b1},
    '{1'b0, 1'b1, 13'd0,    16'd0,     16'd0, 16'd0,     13'd8190, 1'b0, 8'd0,   1'b0},
    '{1'b0, 1'b1, 13'd0,    16'd0,     16'd0, 16'd0,     13'd8000, 1'b0, 8'd0,   1'b0},
    '{1'b1, 1'b1, 13'd4096, 16'd4096,  16'd0, 16'd0,     13'd4097, 1'b1, 8'd0,   1'b1},
    '{1'b0, 1'b1, 13'd0,    16'd0,     16'd0, 16'd0,     13'd8191, 1'b1, 8'd0,   1'b1},
    '{1'b0, 1'b1, 13'd0,    16'd0,     16'd0, 16'd0,     13'd4096, 1'b1, 8'd0,   1'b1},
    '{1'b0, 1'b1, 13'd0,    16'd0,     16'd0, 16'd0,     13'd0,    1'b1, 8'd255, 1'b1},
    '{1'b0, 1'b1, 13'd0,    16'd0,     16'd0, 16'd0,     13'd4000, 1'b0, 8'd0,   1'b0},
    '{1'b1, 1'b1, 13'd8191, 16'd0,     16'd0, 16'd65535, 13'd0,    1'b1, 8'd255, 1'b1},
    '{1'b0, 1'b1, 13'd0,    16'd0,     16'd0, 16'd0,     13'd8191, 1'b1, 8'd0,   1'b1},
    '{1'b0, 1'b1, 13'd0,    16'd0,     16'd0, 16'd0,     13'd8191, 1'b1, 8'd0,   1'b1},
    '{1'b0, 1'b1, 13'd0,    16'd0,     16'd0, 16'd0,     13'd8180, 1'b0, 8'd0,   1'b0},
    '{1'b1, 1'b1, 13'd8191, 16'd256,   16'd0, 16'd0,     13'd0,    1'b0, 8'd0,   1'b0},
    '{1'b0, 1'b1, 13'd0,    16'd0,     16'd0, 16'd0,     13'd5000, 1'b0, 8'd0,   1'b0},
    '{1'b1, 1'b0, 13'd8191, 16'd256,   16'd0, 16'd0,     13'd123,  1'b0, 8'd0,   1'b0},
    '{1'b0, 1'b0, 13'd0,    16'd0,     16'd0, 16'd0,     13'd8191, 1'b0, 8'd0,   1'b0},
    '{1'b1, 1'b1, 13'd8191, 16'd1,     16'd1, 16'd1,     13'd8191, 1'b0, 8'd0,   1'b0},
    '{1'b0, 1'b1, 13'd0,    16'd0,     16'd0, 16'd0,     13'd8000, 1'b0, 8'd0,   1'b0}
  };

  // one control tick of the positional pid controller
  function automatic void pid_tick(input meas_t meas, output duty_t duty, output logic updated);
    longint err;
    longint derr;
    longint add;
    longint sum;
    longint level;
    if (!ctl_enable) begin
      duty    = duty_last;
      updated = 1'b0;
      return;
    end
    if (ctl_setpoint == '0 || meas > ctl_setpoint) begin
      duty_last = '0;
      duty      = '0;
      updated   = 1'b1;
      return;
    end
    err  = longint'(ctl_setpoint) - longint'(meas);
    derr = err - longint'(last_error);
    last_error = err[hpd_pkg::ErrWidth-1:0];
    add = err * longint'(ctl_ki);
    if (integral_acc > IntegralCap || add > IntegralCap - integral_acc) begin
      integral_acc = IntegralCap;
    end else begin
      integral_acc = integral_acc + add;
    end
    sum = err * longint'(ctl_kp) + integral_acc + derr * longint'(ctl_kd);
    if (sum <= 0) begin
      level = 0;
    end else begin
      level = sum >>> hpd_pkg::OutShift;
      if (level > longint'(hpd_pkg::DutyMax)) level = longint'(hpd_pkg::DutyMax);
    end
    duty_last = level[hpd_pkg::DutyWidth-1:0];
    duty      = duty_last;
    updated   = 1'b1;
  endfunction

  // mostly small errors below the setpoint, some overshoot and plain noise
  function automatic meas_t pick_measured(input meas_t sp);
    int unsigned roll;
    int unsigned span;
    roll = $urandom_range(0, 99);
    span = (sp < 64) ? sp : 64;
    if (roll < 75) return sp - meas_t'($urandom_range(0, span));
    if (roll < 82) return meas_t'($urandom_range(0, sp));
    if (roll < 90) begin
      if (sp == meas_t'(MeasTop)) return sp;
      span = (MeasTop - sp < 64) ? MeasTop - sp : 64;
      return sp + meas_t'($urandom_range(1, span));
    end
    return meas_t'($urandom_range(0, MeasTop));
  endfunction

  task automatic send_tick(input meas_t meas, input bit known, input duty_t duty,
                           input logic updated);
    int           gap;
    duty_expect_t want;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    measured_i <= meas;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    pid_tick(meas, want.duty, want.updated);
    if (known) begin
      want.duty    = duty;
      want.updated = updated;
    end
    duty_expect_q.push_back(want);
  endtask

  // registers change only with nothing in flight
  task automatic write_regs(input logic en, input meas_t sp, input gain_t kp,
                            input gain_t ki, input gain_t kd);
    logic [hpd_pkg::CfgDataWidth-1:0] vals [NumCfgRegs];
    int                               r;
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (duty_expect_q.size() != 0) @(posedge clk_i);
    // junk above the register width must be dropped
    vals[hpd_pkg::CFG_ENABLE]    = {(hpd_pkg::CfgDataWidth-1)'($urandom), en};
    vals[hpd_pkg::CFG_SETPOINT]  = {3'($urandom_range(0, 7)), sp};
    vals[hpd_pkg::CFG_GAIN_P]    = kp;
    vals[hpd_pkg::CFG_GAIN_I_DT] = ki;
    vals[hpd_pkg::CFG_GAIN_D_DT] = kd;
    for (r = 0; r < NumCfgRegs; r++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= hpd_pkg::cfg_reg_e'(r);
      cfg_data_i <= vals[r];
      @(posedge clk_i);
    end
    // an index past the register list is ignored
    cfg_idx_i  <= hpd_pkg::CfgIdxWidth'($urandom_range(NumCfgRegs, CfgIdxTop));
    cfg_data_i <= hpd_pkg::CfgDataWidth'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ctl_enable   = en;
    ctl_setpoint = sp;
    ctl_kp       = kp;
    ctl_ki       = ki;
    ctl_kd       = kd;
  endtask

  // receiver stall in changing modes
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_tick = 0;

  always @(posedge clk_i) begin
    stall_tick++;
    if (stall_tick % 97 == 0) stall_mode = stall_mode_e'($urandom_range(0, 2));
    case (stall_mode)
      STALL_NONE: begin
        out_stall_i <= 1'b0;
      end
      STALL_COIN: begin
        out_stall_i <= ($urandom_range(0, 1) == 1);
      end
      default: begin
        out_stall_i <= ((stall_tick % 7) < 3);
      end
    endcase
  end

  always @(posedge clk_i) begin
    duty_expect_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (duty_expect_q.size() == 0) begin
        $error("result with nothing pending: duty %0d updated %0b", duty_o, updated_o);
        mismatches++;
      end else begin
        want = duty_expect_q.pop_front();
        if (duty_o !== want.duty) begin
          $error("duty: expected %0d, got %0d", want.duty, duty_o);
          mismatches++;
        end
        if (updated_o !== want.updated) begin
          $error("updated: expected %0b, got %0b", want.updated, updated_o);
          mismatches++;
        end
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("[heater_pid_duty] ERROR");
      $finish;
    end
  end

  initial begin
    int    ph;
    int    n;
    logic  en;
    meas_t sp;
    gain_t kp;
    gain_t ki;
    gain_t kd;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr_cfg) begin
        write_regs(dir_rows[i].en, dir_rows[i].sp, dir_rows[i].kp, dir_rows[i].ki,
                   dir_rows[i].kd);
      end
      send_tick(dir_rows[i].meas, dir_rows[i].known, dir_rows[i].duty, dir_rows[i].updated);
    end

    for (ph = 0; ph < RandPhases; ph++) begin
      en = ($urandom_range(0, 7) != 0);
      case ($urandom_range(0, 5))
        0:       sp = '0;
        1:       sp = meas_t'(MeasTop);
        default: sp = meas_t'($urandom_range(1, MeasTop));
      endcase
      kp = $urandom_range(0, 1) ? gain_t'($urandom_range(0, GainTop))
                                : gain_t'($urandom_range(0, 2047));
      // the integral never shrinks, so keep it small until the last phase
      ki = ($urandom_range(0, 2) == 0) ? gain_t'($urandom_range(1, 3)) : '0;
      kd = $urandom_range(0, 1) ? gain_t'($urandom_range(0, GainTop))
                                : gain_t'($urandom_range(0, 1023));
      if (ph == RandPhases - 1) begin
        en = 1'b1;
        sp = meas_t'(MeasTop);
        ki = gain_t'(GainTop);
      end
      write_regs(en, sp, kp, ki, kd);
      for (n = 0; n < PhaseItems; n++) begin
        send_tick(pick_measured(sp), 1'b0, '0, 1'b0);
      end
    end

    in_valid_i <= 1'b0;
    while (duty_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[heater_pid_duty] OK");
    end else begin
      $display("[heater_pid_duty] ERROR");
    end
    $finish;
  end

endmodule
